// ----- design/csvfs_pkg.sv -----
// Shared types and constants for the CSV field splitter.
package csvfs_pkg;

  // Character codes the parser reacts to
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_NUL     = 8'h00;

  // Reset value of the field separator (comma)
  localparam logic [7:0] SEP_RESET = 8'h2C;

  // Result queue depth and derived widths
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // Parser modes, one-hot
  typedef enum logic [5:0] {
    MODE_LINE_START  = 6'b000001,
    MODE_FIELD_START = 6'b000010,
    MODE_PLAIN       = 6'b000100,
    MODE_QUOTED      = 6'b001000,
    MODE_QUOTE_SEEN  = 6'b010000,
    MODE_DONE        = 6'b100000
  } mode_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field_end;
    logic       line_end;
    logic       run_last;
  } result_t;

  // Results produced by one input byte
  typedef struct packed {
    result_t [1:0] res;   // res[0] is delivered first
    logic    [1:0] count; // 0, 1 or 2
  } step_out_t;

endpackage

// ----- design/csvfs_step.sv -----
// Per-byte parse step: next mode and the results one byte produces.
module csvfs_step (
  input  csvfs_pkg::mode_t     mode,
  input  logic [7:0]           data_byte,
  input  logic                 is_last,
  input  logic [7:0]           field_separator,
  output csvfs_pkg::mode_t     mode_next,
  output csvfs_pkg::step_out_t step_out
);

  csvfs_pkg::mode_t   cur;
  csvfs_pkg::mode_t   mid;
  csvfs_pkg::result_t prim;
  csvfs_pkg::result_t tail;
  logic               prim_v;
  logic               tail_v;
  logic               open;

  // Unused mode codes behave as line start
  always_comb begin
    unique case (mode)
      csvfs_pkg::MODE_LINE_START,
      csvfs_pkg::MODE_FIELD_START,
      csvfs_pkg::MODE_PLAIN,
      csvfs_pkg::MODE_QUOTED,
      csvfs_pkg::MODE_QUOTE_SEEN,
      csvfs_pkg::MODE_DONE:        cur = mode;
      default:                     cur = csvfs_pkg::MODE_LINE_START;
    endcase
  end

  // Byte handling
  always_comb begin
    prim   = '0;
    prim_v = 1'b0;
    mid    = cur;
    open   = (cur != csvfs_pkg::MODE_LINE_START);
    if (cur != csvfs_pkg::MODE_DONE) begin
      priority if (data_byte == csvfs_pkg::CH_NUL) begin
        prim_v         = open;
        prim.field_end = 1'b1;
        prim.line_end  = 1'b1;
        mid            = csvfs_pkg::MODE_DONE;
      end else if (data_byte == csvfs_pkg::CH_NEWLINE) begin
        prim_v         = open;
        prim.field_end = 1'b1;
        prim.line_end  = 1'b1;
        mid            = csvfs_pkg::MODE_LINE_START;
      end else if (cur == csvfs_pkg::MODE_QUOTED) begin
        if (data_byte == csvfs_pkg::CH_QUOTE) begin
          mid = csvfs_pkg::MODE_QUOTE_SEEN;
        end else begin
          prim_v          = 1'b1;
          prim.out_byte   = data_byte;
          prim.byte_valid = 1'b1;
        end
      end else if (cur == csvfs_pkg::MODE_QUOTE_SEEN &&
                   data_byte == csvfs_pkg::CH_QUOTE) begin
        // doubled quote gives one literal quote
        prim_v          = 1'b1;
        prim.out_byte   = csvfs_pkg::CH_QUOTE;
        prim.byte_valid = 1'b1;
        mid             = csvfs_pkg::MODE_QUOTED;
      end else if (data_byte == field_separator) begin
        prim_v         = 1'b1;
        prim.field_end = 1'b1;
        mid            = csvfs_pkg::MODE_FIELD_START;
      end else if (data_byte == csvfs_pkg::CH_QUOTE &&
                   (cur == csvfs_pkg::MODE_LINE_START ||
                    cur == csvfs_pkg::MODE_FIELD_START)) begin
        mid = csvfs_pkg::MODE_QUOTED;
      end else begin
        prim_v          = 1'b1;
        prim.out_byte   = data_byte;
        prim.byte_valid = 1'b1;
        mid             = csvfs_pkg::MODE_PLAIN;
      end
    end
  end

  // End of file closes an open line and rearms for a new file
  always_comb begin
    tail           = '0;
    tail.field_end = 1'b1;
    tail.line_end  = 1'b1;
    tail.run_last  = 1'b1;
    tail_v         = is_last && (mid != csvfs_pkg::MODE_LINE_START) &&
                     (mid != csvfs_pkg::MODE_DONE);
    mode_next      = is_last ? csvfs_pkg::MODE_LINE_START : mid;
  end

  // Order results: byte result first, line close second
  always_comb begin
    csvfs_pkg::result_t first;
    first          = prim;
    first.run_last = !tail_v;
    step_out.res[0] = prim_v ? first : tail;
    step_out.res[1] = tail;
    step_out.count  = {1'b0, prim_v} + {1'b0, tail_v};
  end

endmodule

// ----- design/csv_field_splitter.sv -----
// Top level of the CSV field splitter: input handshake, separator and mode registers, result queue.
//
// Usage:
//   s_axis_* carries one text byte per item (tdata = data_byte, tlast = is_last).
//   m_axis_* carries result items: tdata = out_byte, tuser = byte_valid,
//   field_end, line_end (from bit 0 up), tlast = last result of its input byte.
//   cfg_we/cfg_wdata write the field separator; write only while idle.
// Each result is written into the result queue and offered from there.
// Throughput: one byte per cycle while the receiver takes results and each
//   byte makes at most one result; for a byte that makes two results (last
//   byte closing a line) the extra result is absorbed by the four-entry result queue.
// The input takes a byte whenever the queue has room for two results, so a
//   byte can be accepted while earlier results still wait to be taken.
// When the receiver stalls, the queue fills and s_axis_tready drops; no
//   result is lost or repeated.
// Reset: synchronous, active high; clears the queue, sets the mode to line
//   start and the separator to a comma.
module csv_field_splitter (
  input  logic       clk,
  input  logic       rst,
  // config
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,     // field_separator
  // input stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
  input  logic       s_axis_tlast,  // is_last
  // output stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] out_byte
  output logic [2:0] m_axis_tuser,  // [0] byte_valid, [1] field_end, [2] line_end
  output logic       m_axis_tlast   // run_last
);

  logic [7:0]                  field_separator;
  csvfs_pkg::mode_t            mode;
  csvfs_pkg::mode_t            mode_next;
  csvfs_pkg::step_out_t        step_out;
  csvfs_pkg::result_t          queue [csvfs_pkg::QDepth];
  logic [csvfs_pkg::QPtrW-1:0] wr_ptr;
  logic [csvfs_pkg::QPtrW-1:0] rd_ptr;
  logic [csvfs_pkg::QCntW-1:0] count;
  logic                        in_acc;
  logic                        out_acc;
  logic [1:0]                  push_n;
  csvfs_pkg::result_t          head;

  // Parse step
  csvfs_step u_step (
    .mode            (mode),
    .data_byte       (s_axis_tdata),
    .is_last         (s_axis_tlast),
    .field_separator (field_separator),
    .mode_next       (mode_next),
    .step_out        (step_out)
  );

  // Handshakes
  assign s_axis_tready = (count <= csvfs_pkg::QCntW'(csvfs_pkg::QDepth - 2));
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign push_n        = in_acc ? step_out.count : 2'd0;

  // Separator register
  always_ff @(posedge clk) begin
    if (rst) begin
      field_separator <= csvfs_pkg::SEP_RESET;
    end else if (cfg_we) begin
      field_separator <= cfg_wdata;
    end
  end

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= csvfs_pkg::MODE_LINE_START;
    end else if (in_acc) begin
      mode <= mode_next;
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= step_out.res[0];
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + csvfs_pkg::QPtrW'(1)] <= step_out.res[1];
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + csvfs_pkg::QPtrW'(push_n);
      rd_ptr <= rd_ptr + csvfs_pkg::QPtrW'(out_acc);
      count  <= count + csvfs_pkg::QCntW'(push_n) - csvfs_pkg::QCntW'(out_acc);
    end
  end

  // Output side
  assign head          = queue[rd_ptr];
  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = head.out_byte;
  assign m_axis_tuser  = {head.line_end, head.field_end, head.byte_valid};
  assign m_axis_tlast  = head.run_last;

endmodule

// ----- design/csvfs_checker.sv -----
// Port-level checks for the CSV field splitter, bound to the top level.
module csvfs_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [2:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // Reset empties the result queue
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result offered right after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

  // A character result never also ends a field
  a_char_not_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1] && !m_axis_tuser[2])
    else $error("character result carries a boundary");

  // Line end comes only with field end
  a_line_needs_field: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1])
    else $error("line end without field end");

  // Boundary-only results carry a zero byte
  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'h00)
    else $error("nonzero byte on a boundary result");

endmodule

bind csv_field_splitter csvfs_checker u_csvfs_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
